### rtl/core/bdpd_pkg.sv
`default_nettype none
package bdpd_pkg;

	// Sizes of the configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Default number of buttons
	localparam int NUM_BUTTONS_DEF = 4;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL       = 3'd4;

	// Register values after reset
	localparam logic [7:0]  RST_TICK_PERIOD         = 8'd10;
	localparam logic [15:0] RST_LONG_PRESS_TIME     = 16'd1000;
	localparam logic [15:0] RST_DOUBLE_CLICK_WINDOW = 16'd300;
	localparam logic        RST_DOUBLE_CLICK_ENABLE = 1'b1;
	localparam logic        RST_PRESSED_LEVEL       = 1'b0;

	// Function codes of an input item
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// Saturation limit of the click counter
	localparam logic [1:0] CLICKS_MAX = 2'd3;
	localparam logic [1:0] CLICKS_ONE = 2'd1;
	localparam logic [1:0] CLICKS_TWO = 2'd2;

	typedef struct packed {
		logic [7:0]  tick_period;
		logic [15:0] long_press_time;
		logic [15:0] double_click_window;
		logic        double_click_enable;
		logic        pressed_level;
	} cfg_t;

	typedef struct packed {
		logic        older_sample;
		logic        newer_sample;
		logic        stable_level;
		logic        previous_stable;
		logic        press_seen;
		logic        held_long;
		logic [15:0] hold_countdown;
		logic [1:0]  clicks;
		logic        click_counted;
		logic [15:0] release_countdown;
		logic        double_seen;
	} btn_state_t;

	typedef struct packed {
		logic stable_pressed;
		logic press_flag;
		logic long_press_flag;
		logic double_click_flag;
	} flags_t;

	// Button state after reset: idle level is the inverse of the reset pressed level
	localparam btn_state_t RST_BTN_STATE = '{
		older_sample:      ~RST_PRESSED_LEVEL,
		newer_sample:      ~RST_PRESSED_LEVEL,
		stable_level:      ~RST_PRESSED_LEVEL,
		previous_stable:   ~RST_PRESSED_LEVEL,
		press_seen:        1'b0,
		held_long:         1'b0,
		hold_countdown:    RST_LONG_PRESS_TIME,
		clicks:            2'd0,
		click_counted:     1'b0,
		release_countdown: RST_DOUBLE_CLICK_WINDOW,
		double_seen:       1'b0
	};

endpackage
`default_nettype wire

### rtl/core/bdpd_item_if.sv
`default_nettype none
interface bdpd_item_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [1:0] button;
	logic       pin_level;

	modport source (output valid, output func, output button, output pin_level, input ready);
	modport sink (input valid, input func, input button, input pin_level, output ready);
endinterface
`default_nettype wire

### rtl/core/bdpd_result_if.sv
`default_nettype none
interface bdpd_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] button_id;
	logic       stable_pressed;
	logic       press_flag;
	logic       long_press_flag;
	logic       double_click_flag;

	modport source (output valid, output button_id, output stable_pressed, output press_flag,
		output long_press_flag, output double_click_flag, input ready);
	modport sink (input valid, input button_id, input stable_pressed, input press_flag,
		input long_press_flag, input double_click_flag, output ready);
endinterface
`default_nettype wire

### rtl/core/bdpd_cfg_regs.sv
`default_nettype none
module bdpd_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [bdpd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bdpd_pkg::CFG_DATA_W-1:0] wr_data,
	output bdpd_pkg::cfg_t                      cfg
);
	import bdpd_pkg::*;

	cfg_t cfg_q;

	// Load the addressed register; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period         <= RST_TICK_PERIOD;
			cfg_q.long_press_time     <= RST_LONG_PRESS_TIME;
			cfg_q.double_click_window <= RST_DOUBLE_CLICK_WINDOW;
			cfg_q.double_click_enable <= RST_DOUBLE_CLICK_ENABLE;
			cfg_q.pressed_level       <= RST_PRESSED_LEVEL;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TICK_PERIOD:         cfg_q.tick_period         <= wr_data[7:0];
				REG_LONG_PRESS_TIME:     cfg_q.long_press_time     <= wr_data[15:0];
				REG_DOUBLE_CLICK_WINDOW: cfg_q.double_click_window <= wr_data[15:0];
				REG_DOUBLE_CLICK_ENABLE: cfg_q.double_click_enable <= wr_data[0];
				REG_PRESSED_LEVEL:       cfg_q.pressed_level       <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

### rtl/core/bdpd_state_mem.sv
`default_nettype none
module bdpd_state_mem #(
	parameter int DEPTH  = bdpd_pkg::NUM_BUTTONS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	output bdpd_pkg::btn_state_t     rd_data,
	input  wire logic                wr_en,
	input  wire logic [ADDR_W-1:0]   wr_addr,
	input  wire bdpd_pkg::btn_state_t wr_data
);
	import bdpd_pkg::*;

	btn_state_t          mem [DEPTH];
	logic [DEPTH-1:0]    valid_q;
	btn_state_t          rd_q;
	logic                rd_valid_q;
	logic                fwd_hit_q;
	btn_state_t          fwd_data_q;

	// Write back updated state
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Registered read; capture a write to the same entry on the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
			fwd_hit_q  <= 1'b0;
		end else if (rd_en) begin
			rd_valid_q <= valid_q[rd_addr];
			fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
		end
	end

	// Forward the colliding write, else stored data, else the reset state
	always_comb begin
		if (fwd_hit_q) begin
			rd_data = fwd_data_q;
		end else if (rd_valid_q) begin
			rd_data = rd_q;
		end else begin
			rd_data = RST_BTN_STATE;
		end
	end
endmodule
`default_nettype wire

### rtl/core/bdpd_update.sv
`default_nettype none
module bdpd_update (
	input  wire bdpd_pkg::cfg_t       cfg,
	input  wire bdpd_pkg::btn_state_t cur,
	input  wire logic                 func,
	input  wire logic                 pin_level,
	output bdpd_pkg::btn_state_t      nxt,
	output bdpd_pkg::flags_t          flags
);
	import bdpd_pkg::*;

	logic [15:0] tick_ext;
	logic [15:0] hold_dec;
	logic [15:0] rel_dec;
	logic        stable;
	logic [1:0]  clicks_inc;

	// Saturating countdowns
	assign tick_ext = {8'd0, cfg.tick_period};
	assign hold_dec = (cur.hold_countdown > tick_ext) ? (cur.hold_countdown - tick_ext) : 16'd0;
	assign rel_dec  = (cur.release_countdown > tick_ext) ?
		(cur.release_countdown - tick_ext) : 16'd0;

	// Stable level follows the pin once two samples agree
	assign stable = (pin_level == cur.newer_sample) ? pin_level : cur.stable_level;

	always_comb begin
		clicks_inc = cur.clicks;
		if (!cur.click_counted && (cur.clicks != CLICKS_MAX)) begin
			clicks_inc = cur.clicks + 2'd1;
		end
	end

	// Next button state
	always_comb begin
		nxt = cur;
		if (func == FUNC_CLEAR) begin
			nxt.press_seen = 1'b0;
		end else begin
			nxt.older_sample    = cur.newer_sample;
			nxt.newer_sample    = pin_level;
			nxt.stable_level    = stable;
			nxt.previous_stable = stable;
			if (stable == cfg.pressed_level) begin
				if (cur.previous_stable != stable) begin
					nxt.press_seen = 1'b1;
				end
				if (cur.hold_countdown != 16'd0) begin
					nxt.hold_countdown = hold_dec;
				end else begin
					nxt.held_long = 1'b1;
				end
				if (cfg.double_click_enable) begin
					nxt.click_counted     = 1'b1;
					nxt.release_countdown = cfg.double_click_window;
					if (clicks_inc == CLICKS_TWO) begin
						nxt.double_seen = 1'b1;
						nxt.clicks      = 2'd0;
					end else begin
						nxt.clicks = clicks_inc;
					end
				end
			end else begin
				nxt.hold_countdown = cfg.long_press_time;
				nxt.press_seen     = 1'b0;
				nxt.held_long      = 1'b0;
				if (cfg.double_click_enable) begin
					nxt.click_counted = 1'b0;
					nxt.double_seen   = 1'b0;
					if (cur.clicks == CLICKS_ONE) begin
						nxt.release_countdown = rel_dec;
						if (rel_dec == 16'd0) begin
							nxt.clicks = 2'd0;
						end
					end
				end
			end
		end
	end

	// Report flags as they stand after the item
	assign flags.stable_pressed    = (nxt.stable_level == cfg.pressed_level);
	assign flags.press_flag        = nxt.press_seen;
	assign flags.long_press_flag   = nxt.held_long;
	assign flags.double_click_flag = cfg.double_click_enable && nxt.double_seen;
endmodule
`default_nettype wire

### rtl/core/button_debounce_press_detector_core.sv
`default_nettype none
// Button debounce and press detector for up to NUM_BUTTONS buttons.
// Channel item: one transaction per sample tick (func tick, button, raw pin
// level) or clear command (func clear, button) that drops the press flag.
// Channel result: one transaction per item with button_id, the debounced
// pressed level and the press, long-press and double-click flags, in item order.
// Buttons at or beyond NUM_BUTTONS return zero flags and change nothing.
// Flow: the state memory read is registered when the item is taken; the
// update, write-back and result register load follow once the update stage
// advances, and the result is then offered from the result register.
// Throughput: one item per cycle, any button mix, unless results stall; a write
// to the entry read is forwarded; back-to-back ticks on one button are exact.
// Configuration: plain write port, registers take effect on the next item.
// Reset: registers return to defaults and every button reads its reset state
// until first written; no clearing pass is needed, items are taken at once.
// Stall: when result is not taken, the result register holds, the update
// stage holds one more item, and item ready drops until the result drains.
module button_debounce_press_detector_core #(
	parameter int NUM_BUTTONS = bdpd_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bdpd_item_if.sink                           item,
	bdpd_result_if.source                       result,
	input  wire logic                           wr_en,
	input  wire logic [bdpd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bdpd_pkg::CFG_DATA_W-1:0] wr_data
);
	import bdpd_pkg::*;

	localparam int ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	cfg_t        cfg;
	btn_state_t  rd_state;
	btn_state_t  nxt_state;
	flags_t      flags;

	logic        accept;
	logic        adv;
	logic        valid_s1;
	logic        func_s1;
	logic [1:0]  button_s1;
	logic        pin_s1;
	logic        in_range_s1;
	logic        mem_wr_en;

	logic        out_valid_q;
	logic [1:0]  out_button_q;
	flags_t      out_flags_q;

	bdpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Handshake: the update stage moves when the result register is free
	assign adv        = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || adv;
	assign accept     = item.valid && item.ready;
	assign mem_wr_en  = valid_s1 && adv && in_range_s1;

	bdpd_state_mem #(
		.DEPTH  (NUM_BUTTONS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (ADDR_W'(item.button)),
		.rd_data (rd_state),
		.wr_en   (mem_wr_en),
		.wr_addr (ADDR_W'(button_s1)),
		.wr_data (nxt_state)
	);

	// Update stage: hold the item while its state is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= item.func;
			button_s1   <= item.button;
			pin_s1      <= item.pin_level;
			in_range_s1 <= (32'(item.button) < NUM_BUTTONS);
		end
	end

	bdpd_update u_upd (
		.cfg       (cfg),
		.cur       (rd_state),
		.func      (func_s1),
		.pin_level (pin_s1),
		.nxt       (nxt_state),
		.flags     (flags)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			out_button_q <= button_s1;
			out_flags_q  <= in_range_s1 ? flags : '0;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.button_id         = out_button_q;
	assign result.stable_pressed    = out_flags_q.stable_pressed;
	assign result.press_flag        = out_flags_q.press_flag;
	assign result.long_press_flag   = out_flags_q.long_press_flag;
	assign result.double_click_flag = out_flags_q.double_click_flag;
endmodule
`default_nettype wire
